@@ rtl/fti_pkg.sv @@
// ----------------------------------------------------------------------------
// fti_pkg: shared definitions of the frame time integrator
// Default sizes, fixed field widths, register indexes and the flag bundle
// that travels with each queued sample.
// ----------------------------------------------------------------------------
`default_nettype none

package fti_pkg;

   localparam int FRAME_DEPTH_DEF = 4096;
   localparam int MAX_GROUP_DEF   = 4096;
   localparam int SAMPLE_BITS_DEF = 32;

   localparam int CFG_W       = 13;
   localparam int OUT_W       = 44;
   localparam int IDX_OUT_W   = 12;
   localparam int CSR_IDX_W   = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int RSP_DATA_W  = ((OUT_W + IDX_OUT_W + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_LENGTH       = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENTS_PER_FRAME = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_MODE          = CSR_IDX_W'(2);

   // Classification of one sample, decided in the front end.
   typedef struct packed {
      logic first;   // first frame of a group: overwrite the accumulator
      logic emit;    // last frame of a group: produce a result
      logic last;    // last element of the frame
   } item_flags_type;

   // Index width for a table of the given depth, at least one bit.
   function automatic int idx_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/fti_fifo.sv @@
// ----------------------------------------------------------------------------
// fti_fifo: short queue between front end and back end
// Register-based FIFO with a combinational head; full and empty are derived
// from an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module fti_fifo import fti_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = idx_bits(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fti_front.sv @@
// ----------------------------------------------------------------------------
// fti_front: sample intake, element and frame counting, control registers
// Accepts samples, tags each with its element position and group flags, and
// holds the three control registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fti_front import fti_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
   parameter int MAX_GROUP   = MAX_GROUP_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int IDX_W      = idx_bits(FRAME_DEPTH),
   localparam int GL_W       = $clog2(MAX_GROUP + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SAMPLE_BITS-1:0] in_sample,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CFG_W-1:0]       csr_data,
   input  wire logic                   queue_full,
   output logic                        queue_push,
   output logic [SAMPLE_BITS-1:0]      queue_sample,
   output logic [IDX_W-1:0]            queue_index,
   output item_flags_type              queue_flags,
   output logic                        mean_mode,
   output logic [GL_W-1:0]             group_len
);

   localparam int FR_W = idx_bits(MAX_GROUP);
   localparam int EL_W = $clog2(FRAME_DEPTH + 1);

   logic [CFG_W-1:0] glen_cfg_ff, glen_cfg_in;
   logic [CFG_W-1:0] epf_cfg_ff, epf_cfg_in;
   logic             mean_ff, mean_in;
   logic [IDX_W-1:0] elem_ff, elem_in;
   logic [FR_W-1:0]  frame_ff, frame_in;
   logic [EL_W-1:0]  eff_epf;
   logic [GL_W-1:0]  eff_glen;
   logic             accept;
   logic             cfg_hit;
   item_flags_type   flags;

   // Out-of-range register values are clamped into the legal range.
   always_comb begin
      if (glen_cfg_ff == '0) begin
         eff_glen = GL_W'(1);
      end else if (int'(glen_cfg_ff) > MAX_GROUP) begin
         eff_glen = GL_W'(MAX_GROUP);
      end else begin
         eff_glen = GL_W'(glen_cfg_ff);
      end
      if (epf_cfg_ff == '0) begin
         eff_epf = EL_W'(1);
      end else if (int'(epf_cfg_ff) > FRAME_DEPTH) begin
         eff_epf = EL_W'(FRAME_DEPTH);
      end else begin
         eff_epf = EL_W'(epf_cfg_ff);
      end
   end

   assign in_ready   = !queue_full;
   assign accept     = in_valid && !queue_full;
   assign csr_ready  = 1'b1;
   assign cfg_hit    = csr_valid && (csr_index == CSR_GROUP_LENGTH ||
                                     csr_index == CSR_ELEMENTS_PER_FRAME ||
                                     csr_index == CSR_MEAN_MODE);

   assign flags.first = (frame_ff == '0);
   assign flags.emit  = (GL_W'(frame_ff) >= eff_glen - GL_W'(1));
   assign flags.last  = (EL_W'(elem_ff) == eff_epf - EL_W'(1));

   assign queue_push   = accept;
   assign queue_sample = in_sample;
   assign queue_index  = elem_ff;
   assign queue_flags  = flags;
   assign mean_mode    = mean_ff;
   assign group_len    = eff_glen;

   always_comb begin
      glen_cfg_in = glen_cfg_ff;
      epf_cfg_in  = epf_cfg_ff;
      mean_in     = mean_ff;
      elem_in     = elem_ff;
      frame_in    = frame_ff;
      if (cfg_hit) begin
         unique case (csr_index)
            CSR_GROUP_LENGTH:       glen_cfg_in = csr_data;
            CSR_ELEMENTS_PER_FRAME: epf_cfg_in  = csr_data;
            default:                mean_in     = csr_data[0];
         endcase
         elem_in  = '0;
         frame_in = '0;
      end else if (accept) begin
         if (flags.last) begin
            elem_in  = '0;
            frame_in = flags.emit ? '0 : frame_ff + FR_W'(1);
         end else begin
            elem_in = elem_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glen_cfg_ff <= CFG_W'(1);
         epf_cfg_ff  <= CFG_W'(1);
         mean_ff     <= 1'b0;
         elem_ff     <= '0;
         frame_ff    <= '0;
      end else begin
         glen_cfg_ff <= glen_cfg_in;
         epf_cfg_ff  <= epf_cfg_in;
         mean_ff     <= mean_in;
         elem_ff     <= elem_in;
         frame_ff    <= frame_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fti_back.sv @@
// ----------------------------------------------------------------------------
// fti_back: accumulation, mean division and result register
// Reads and updates the accumulator memory for each queued sample, divides
// by the group length one quotient bit per cycle in mean mode, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fti_back import fti_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
   parameter int MAX_GROUP   = MAX_GROUP_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int IDX_W      = idx_bits(FRAME_DEPTH),
   localparam int GL_W       = $clog2(MAX_GROUP + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   queue_empty,
   output logic                        queue_pop,
   input  wire logic [SAMPLE_BITS-1:0] queue_sample,
   input  wire logic [IDX_W-1:0]       queue_index,
   input  wire item_flags_type         queue_flags,
   input  wire logic                   mean_mode,
   input  wire logic [GL_W-1:0]        group_len,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [OUT_W-1:0]            out_integrated,
   output logic [IDX_OUT_W-1:0]        out_index,
   output logic                        out_last
);

   // Wide enough for a full group of extreme samples.
   localparam int ACC_W = SAMPLE_BITS + $clog2(MAX_GROUP);
   localparam int CNT_W = $clog2(ACC_W + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ACC  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } back_state_type;

   logic [ACC_W-1:0] acc_mem [FRAME_DEPTH];

   back_state_type          state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   item_flags_type          flags_ff, flags_in;
   logic [ACC_W-1:0]        rd_data_ff;
   logic [ACC_W-1:0]        res_ff, res_in;
   logic [GL_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic                    out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]        out_int_ff, out_int_in;
   logic [IDX_OUT_W-1:0]    out_idx_ff, out_idx_in;
   logic                    out_last_ff, out_last_in;

   logic signed [ACC_W-1:0] sample_ext;
   logic [ACC_W-1:0]        sum;
   logic [ACC_W-1:0]        mag;
   logic [GL_W:0]           trial;
   logic [GL_W:0]           diff;
   logic                    fits;
   logic signed [ACC_W-1:0] final_val;
   logic                    mem_we;
   logic                    out_load;

   assign sample_ext = ACC_W'(sample_ff);
   assign sum        = flags_ff.first ? sample_ext : rd_data_ff + sample_ext;
   assign mag        = sum[ACC_W-1] ? -sum : sum;

   // Restoring division step on the magnitude of the sum.
   assign trial = {rem_ff, res_ff[ACC_W-1]};
   assign diff  = trial - {1'b0, group_len};
   assign fits  = (trial >= {1'b0, group_len});

   assign final_val = neg_ff ? -res_ff : res_ff;
   assign out_load  = (state_ff == ST_EMIT) && (!out_valid_ff || out_ready);

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      idx_in    = idx_ff;
      flags_in  = flags_ff;
      res_in    = res_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      queue_pop = 1'b0;
      mem_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               sample_in = queue_sample;
               idx_in    = queue_index;
               flags_in  = queue_flags;
               state_in  = ST_ACC;
            end
         end
         ST_ACC: begin
            mem_we = 1'b1;
            if (!flags_ff.emit) begin
               state_in = ST_IDLE;
            end else if (mean_mode && group_len != GL_W'(1)) begin
               res_in   = mag;
               neg_in   = sum[ACC_W-1];
               rem_in   = '0;
               cnt_in   = CNT_W'(ACC_W);
               state_in = ST_DIV;
            end else begin
               res_in   = sum;
               neg_in   = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            res_in = {res_ff[ACC_W-2:0], fits};
            rem_in = fits ? diff[GL_W-1:0] : trial[GL_W-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_int_in   = out_int_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_int_in   = OUT_W'(final_val);
         out_idx_in   = IDX_OUT_W'(idx_ff);
         out_last_in  = flags_ff.last;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      idx_ff      <= idx_in;
      flags_ff    <= flags_in;
      res_ff      <= res_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      out_int_ff  <= out_int_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   // Accumulator memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         acc_mem[idx_ff] <= sum;
      end
      if (queue_pop) begin
         rd_data_ff <= acc_mem[queue_index];
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_integrated = out_int_ff;
   assign out_index      = out_idx_ff;
   assign out_last       = out_last_ff;

endmodule

`default_nettype wire

@@ rtl/frame_time_integrator_top.sv @@
// The back end pops each sample from the queue, then reads and updates its accumulator; on the
// last frame of a group it runs its serial divider in mean mode and loads the result register.
// It pops no new sample until it is done with the last, so in mean mode the divider sets the rate.
// A 4-entry queue between front and back end absorbs short bursts.
// Reset is synchronous and active high: counters and control registers go
// to their defaults at once; the accumulator memory is not cleared.
// ----------------------------------------------------------------------------
// frame_time_integrator_top: integrate-and-dump over time frames
// Sums each element position of the frame over a configurable group of
// frames and emits the sum, or its mean, on the last frame of each group.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_time_integrator_top import fti_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
   parameter int MAX_GROUP   = MAX_GROUP_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int REQ_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Sample stream.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_W-1:0]      req_tdata,   // sample, zero padding above
   // Result stream.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // integrated, element_index
   output logic                       rsp_tlast,   // frame_last
   // Control register writes.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_data
);

   localparam int IDX_W  = idx_bits(FRAME_DEPTH);
   localparam int GL_W   = $clog2(MAX_GROUP + 1);
   localparam int FLAG_W = $bits(item_flags_type);
   localparam int Q_W    = SAMPLE_BITS + IDX_W + FLAG_W;

   logic                   q_push;
   logic                   q_pop;
   logic                   q_full;
   logic                   q_empty;
   logic [SAMPLE_BITS-1:0] f_sample;
   logic [IDX_W-1:0]       f_index;
   item_flags_type         f_flags;
   logic [Q_W-1:0]         q_wr_data;
   logic [Q_W-1:0]         q_rd_data;
   logic [SAMPLE_BITS-1:0] b_sample;
   logic [IDX_W-1:0]       b_index;
   item_flags_type         b_flags;
   logic                   mean_mode;
   logic [GL_W-1:0]        group_len;
   logic [OUT_W-1:0]       rsp_integrated;
   logic [IDX_OUT_W-1:0]   rsp_index;

   // The front end counts elements and frames as samples arrive, so each
   // transaction is classified before it reaches the queue. The back end
   // then only has to read, update and possibly emit.
   fti_front #(
      .FRAME_DEPTH (FRAME_DEPTH),
      .MAX_GROUP   (MAX_GROUP),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_sample    (req_tdata[SAMPLE_BITS-1:0]),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .queue_full   (q_full),
      .queue_push   (q_push),
      .queue_sample (f_sample),
      .queue_index  (f_index),
      .queue_flags  (f_flags),
      .mean_mode    (mean_mode),
      .group_len    (group_len)
   );

   assign q_wr_data = {f_flags, f_index, f_sample};

   fti_fifo #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   assign b_sample = q_rd_data[SAMPLE_BITS-1:0];
   assign b_index  = q_rd_data[SAMPLE_BITS +: IDX_W];
   assign b_flags  = item_flags_type'(q_rd_data[Q_W-1 -: FLAG_W]);

   // Mean mode and group length are read straight from the control registers; the user
   // must change them only while no transaction is in flight; the block does not enforce it.
   fti_back #(
      .FRAME_DEPTH (FRAME_DEPTH),
      .MAX_GROUP   (MAX_GROUP),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (q_empty),
      .queue_pop      (q_pop),
      .queue_sample   (b_sample),
      .queue_index    (b_index),
      .queue_flags    (b_flags),
      .mean_mode      (mean_mode),
      .group_len      (group_len),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_integrated (rsp_integrated),
      .out_index      (rsp_index),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_index, rsp_integrated});

endmodule

`default_nettype wire

@@ rtl/fti_checker.sv @@
// ----------------------------------------------------------------------------
// fti_checker: port-level checks of the frame time integrator
// Watches the result stream and the control port and reports violations.
// ----------------------------------------------------------------------------
`default_nettype none

module fti_checker import fti_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic                  csr_ready
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result payload changed while stalled");

   // Reset leaves no stale result in the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // Control writes are never back-pressured.
   a_csr_ready: assert property (@(posedge clock)
      !reset |-> csr_ready)
      else $error("control port not ready");

endmodule

bind frame_time_integrator_top fti_checker u_fti_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);

`default_nettype wire

@@ tb/sv/frame_time_integrator_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_time_integrator_top_test: self-checking bench of the frame integrator
// Streams samples under random valid and ready gaps, predicts every sum or
// mean from a model of the counters and accumulators kept here, and compares
// each result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module frame_time_integrator_top_test;
   import fti_pkg::*;

   localparam int CLOCK_PERIOD     = 8;
   localparam int REQ_W            = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
   localparam int MAX_IDLE         = 18;
   // Covers the mean-mode divider and a full queue in front of it, so this
   // settles any sample that produces no result.
   localparam int DRAIN_CYCLES     = 80;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int END_WAIT_CYCLES  = 20000;
   localparam int TIMEOUT_CYCLES   = 600000;
   localparam int RANDOM_ITEMS     = 400;
   localparam int PHASE_CAP        = 90;

   // Register indexes that the block does not decode.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HIGH = {CSR_IDX_W{1'b1}};

   localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;

   typedef struct {
      logic [OUT_W-1:0]     integrated;
      logic [IDX_OUT_W-1:0] element_index;
      logic                 frame_last;
   } sum_entry_type;

   // Tracks the group and element counters and the accumulator memory of
   // the block, and holds the results that accepted samples must produce.
   class frame_sum_predictor;
      logic [CFG_W-1:0] group_length;
      logic [CFG_W-1:0] frame_size;
      logic             mean_mode;
      longint           sums [FRAME_DEPTH_DEF];
      int unsigned      element_count;
      int unsigned      frame_count;
      sum_entry_type    sums_due [$];
      int               mismatches;

      function new();
         group_length  = CFG_W'(1);
         frame_size    = CFG_W'(1);
         mean_mode     = 1'b0;
         element_count = 0;
         frame_count   = 0;
         mismatches    = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      function int pending();
         return sums_due.size();
      endfunction

      // Any decoded write restarts frame and group; others are dropped.
      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            CSR_GROUP_LENGTH:       group_length = value;
            CSR_ELEMENTS_PER_FRAME: frame_size = value;
            CSR_MEAN_MODE:          mean_mode = value[0];
            default:                return;
         endcase
         element_count = 0;
         frame_count   = 0;
      endfunction

      function void note_sample(logic signed [SAMPLE_BITS_DEF-1:0] sample);
         int unsigned   glen;
         int unsigned   epf;
         int unsigned   e;
         longint        value;
         bit            last_elem;
         bit            last_frame;
         sum_entry_type entry;
         glen = (group_length == 0) ? 1 :
                (group_length > MAX_GROUP_DEF) ? MAX_GROUP_DEF : group_length;
         epf  = (frame_size == 0) ? 1 :
                (frame_size > FRAME_DEPTH_DEF) ? FRAME_DEPTH_DEF : frame_size;
         e = (element_count >= epf) ? epf - 1 : element_count;
         last_elem  = (e == epf - 1);
         last_frame = (frame_count >= glen - 1);
         // The first frame of a group overwrites, later frames add.
         if (frame_count == 0)
            sums[e] = sample;
         else
            sums[e] = sums[e] + sample;
         if (last_frame) begin
            value = sums[e];
            if (mean_mode)
               value = value / longint'(glen);
            entry.integrated    = value[OUT_W-1:0];
            entry.element_index = IDX_OUT_W'(e);
            entry.frame_last    = last_elem;
            sums_due.push_back(entry);
         end
         if (last_elem) begin
            element_count = 0;
            frame_count   = last_frame ? 0 : frame_count + 1;
         end else begin
            element_count = e + 1;
         end
      endfunction

      task check_sum(logic [OUT_W-1:0] integrated, logic [IDX_OUT_W-1:0] element_index,
                     logic frame_last);
         sum_entry_type want;
         if (sums_due.size() == 0) begin
            report($sformatf("unexpected result integrated=%h index=%0d last=%b",
                             integrated, element_index, frame_last));
            return;
         end
         want = sums_due.pop_front();
         if (integrated !== want.integrated)
            report($sformatf("integrated %h, expected %h (index %0d)",
                             integrated, want.integrated, want.element_index));
         if (element_index !== want.element_index)
            report($sformatf("element_index %0d, expected %0d",
                             element_index, want.element_index));
         if (frame_last !== want.frame_last)
            report($sformatf("frame_last %b, expected %b (index %0d)",
                             frame_last, want.frame_last, want.element_index));
      endtask

      task report_missing();
         while (sums_due.size() != 0) begin
            report($sformatf("missing result integrated=%h index=%0d",
                             sums_due[0].integrated, sums_due[0].element_index));
            void'(sums_due.pop_front());
         end
      endtask
   endclass

   // Clock and the block's inputs, all at known values from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;    // sample, zero padding above
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // integrated, element_index
   logic                 rsp_tlast;          // frame_last
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_data   = '0;

   frame_sum_predictor sb = new();

   // Random gaps on both sides can be switched off for stretches of the run.
   bit idle_on   = 1'b1;
   // Set by the stimulus to make the receiver hold off for a long while.
   bit long_hold = 1'b0;

   int random_items = 0;

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   frame_time_integrator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Monitor. All handshakes are sampled right after the rising edge, before
   // any nonblocking update of that edge lands, so they see the values that
   // the edge itself saw. Register writes are applied first, then the result
   // is checked, then the accepted sample is added to the prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready)
            sb.check_sum(rsp_tdata[OUT_W-1:0], rsp_tdata[OUT_W +: IDX_OUT_W], rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_sample(req_tdata[SAMPLE_BITS_DEF-1:0]);
      end
   end

   // Receiver. Each transaction is preceded by a random number of cycles
   // with ready low. A long hold request drops ready for a fixed stretch so
   // that the block's queue fills up and it stalls the sample stream.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         n = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid && !long_hold) @(posedge clock);
      end
   end

   // Offers one sample after a random gap and returns at the edge that
   // accepts it, leaving valid high so a back-to-back sample can follow.
   task send_sample(logic [31:0] sample);
      int n;
      n = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tdata  <= REQ_W'(sample);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Sender pause: no samples until every predicted result has arrived.
   task wait_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // The block is idle once all results are in and any sample that makes
   // no result has had time to pass through the back end.
   task wait_idle();
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task csr_write(logic [CSR_IDX_W-1:0] index, int unsigned value);
      csr_index <= index;
      csr_data  <= CFG_W'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task set_config(int unsigned glen, int unsigned epf, bit mean);
      csr_write(CSR_GROUP_LENGTH, glen);
      csr_write(CSR_ELEMENTS_PER_FRAME, epf);
      csr_write(CSR_MEAN_MODE, mean);
   endtask

   // Samples lean toward the extremes and small values near zero, where
   // sums and truncation of the mean are most likely to go wrong.
   function logic [31:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return 32'($urandom_range(0, 511)) - 32'd256;
         default: return $urandom;
      endcase
   endfunction

   // Mostly short groups and frames, sometimes longer ones, and now and
   // then zero, which the block treats as one.
   function int unsigned pick_length();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(7, 40);
         default: return $urandom_range(1, 5);
      endcase
   endfunction

   // One random phase: a fresh setting, whole groups of random samples, and
   // sometimes a trailing partial group that the next write cuts off.
   task run_random_phase();
      int unsigned glen;
      int unsigned epf;
      int unsigned span;
      int unsigned count;
      glen    = pick_length();
      epf     = pick_length();
      idle_on = ($urandom_range(0, 3) != 0);
      set_config(glen, epf, $urandom_range(0, 1));
      span  = ((glen == 0) ? 1 : glen) * ((epf == 0) ? 1 : epf);
      count = span * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0)
         count += $urandom_range(1, span);
      if (count > PHASE_CAP)
         count = PHASE_CAP;
      repeat (count) begin
         send_sample(rand_sample());
         if ($urandom_range(0, 40) == 0)
            wait_results();
      end
      random_items += count;
      wait_idle();
   endtask

   initial begin
      int waited;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: one frame of one element per group, every sample
      // comes straight back as its own result.
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(32'd0);
      wait_idle();

      // Three frames of two elements, summed at the full sample range.
      set_config(3, 2, 0);
      repeat (3) begin
         send_sample(SAMPLE_MAX);
         send_sample(SAMPLE_MIN);
      end
      wait_idle();

      // Mean mode: -2/3 must truncate to zero, not round down to -1.
      csr_write(CSR_MEAN_MODE, 1);
      send_sample(32'hFFFF_FFFF);
      send_sample(SAMPLE_MIN);
      send_sample(32'd0);
      send_sample(SAMPLE_MIN);
      send_sample(32'hFFFF_FFFF);
      send_sample(SAMPLE_MIN);
      wait_idle();

      // Writes to undecoded indexes must not restart the frame in progress.
      set_config(1, 3, 0);
      send_sample(32'h0000_0100);
      wait_idle();
      csr_write(CSR_UNUSED_LOW, 2);
      csr_write(CSR_UNUSED_HIGH, 5);
      send_sample(32'h5555_5555);
      send_sample(32'hAAAA_AAAA);
      wait_idle();

      // Zero group length acts as one: every frame is emitted.
      set_config(0, 2, 0);
      repeat (4) send_sample(rand_sample());
      wait_idle();

      // Zero frame size acts as one element per frame.
      set_config(2, 0, 1);
      repeat (4) send_sample(rand_sample());
      wait_idle();

      // Back pressure: the receiver holds off while samples keep coming, so
      // the queue fills and the block must stall its input.
      set_config(1, 4, 0);
      long_hold = 1'b1;
      repeat (24) send_sample(rand_sample());
      wait_idle();

      // Largest settings run without gaps. The largest group stays open
      // through a short run and emits nothing before the next write.
      idle_on = 1'b0;
      set_config(4096, 1, 0);
      repeat (16) send_sample(SAMPLE_MIN);
      wait_idle();

      // An oversized group length saturates to the largest group, which
      // likewise stays open through a short run.
      set_config(8191, 1, 1);
      repeat (16) send_sample(SAMPLE_MAX);
      wait_idle();

      // An oversized frame saturates to the deepest frame; with a group of
      // one every element comes back at its own position.
      set_config(1, 8191, 0);
      repeat (16) send_sample(rand_sample());
      wait_idle();

      set_config(1, 4096, 1);
      repeat (5) send_sample(rand_sample());
      wait_idle();
      idle_on = 1'b1;

      while (random_items < RANDOM_ITEMS)
         run_random_phase();

      // Final drain with a limit of its own; anything still predicted after
      // that never arrived.
      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < END_WAIT_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.report_missing();

      if (sb.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/fti_pkg.sv
rtl/fti_fifo.sv
rtl/fti_front.sv
rtl/fti_back.sv
rtl/frame_time_integrator_top.sv
rtl/fti_checker.sv
tb/sv/frame_time_integrator_top_test.sv
